>>> src/gflr_pkg.sv
// gflr_pkg: widths, types, codes and the GF(2^16) multiply-by-x helper
// for the lagged recurrence generator; no dependencies
`default_nettype none

package gflr_pkg;

    localparam int WORD_BITS  = 16;
    localparam int RING_DEPTH = 32;
    localparam int IDX_BITS   = $clog2(RING_DEPTH);
    localparam int LAG_BITS   = 5;
    localparam int CFG_BITS   = 1;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [IDX_BITS-1:0]  t_idx;
    typedef logic [LAG_BITS-1:0]  t_lag;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef enum logic [CFG_BITS-1:0] {
        CFG_POLY = 1'b0,
        CFG_LAG  = 1'b1
    } t_cfg_idx;

    localparam t_word POLY_RESET = t_word'(16'h100B);
    localparam t_lag  LAG_RESET  = t_lag'(10);

    // shift left one place, fold the feedback polynomial back in on overflow
    function automatic t_word times_x(input t_word w, input t_word poly);
        t_word shifted;
        shifted = {w[WORD_BITS-2:0], 1'b0};
        if (w[WORD_BITS-1]) begin
            shifted = shifted ^ poly;
        end
        return shifted;
    endfunction

endpackage

`default_nettype wire

>>> src/gf16_lagged_recurrence_generator.sv
// lagged recurrence generator over GF(2^16): ring memory with two read ports,
// one write port, forwarding from the write stage; uses gflr_pkg
//
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+---------------------------------
// s_axis    | in        | tvalid / tready        | tdata = seed_word, tuser = opcode
// m_axis    | out       | tvalid / tready        | tdata = new_word
// cfg       | in        | i_cfg_we (no wait)     | 0 feedback_poly, 1 short_lag
//
// one item per cycle unless a step waits behind an unread result; a step reads
// both words when accepted, then shift-xors, writes back and registers its result
// when the write stage fires; a load writes the ring and gives no result
// reset clears the index, the control flags and the per-entry valid bits at once
// an unread result stalls the input only while a step waits behind it
`default_nettype none

module gf16_lagged_recurrence_generator (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [15:0]            s_axis_tdata,   // [15:0] seed_word
    input  wire                    s_axis_tuser,   // [0] opcode
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [15:0]            m_axis_tdata,   // [15:0] new_word
    input  wire                    i_cfg_we,
    input  wire  [gflr_pkg::CFG_BITS-1:0] i_cfg_addr,
    input  wire  [15:0]            i_cfg_wdata
);
    import gflr_pkg::*;

    // configuration
    t_word r_poly;
    t_lag  r_lag;

    // ring memory and valid bits
    t_word r_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_vld;

    // issue side
    t_idx r_idx;
    t_idx n_idx;
    t_idx n_tap;
    logic [IDX_BITS:0] tap_sum;
    logic accept;

    // write stage
    logic  r_s1_valid;
    t_op   r_s1_op;
    t_word r_s1_seed;
    t_idx  r_s1_addr;
    t_word r_rd_here;
    t_word r_rd_tap;
    logic  r_here_vld;
    logic  r_tap_vld;
    logic  r_fwd_here;
    logic  r_fwd_tap;
    t_word r_fwd_word;
    logic  s1_fire;
    t_word here_w;
    t_word tap_w;
    t_word step_w;
    t_word wr_data;

    // output register
    logic  r_out_valid;
    t_word r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= POLY_RESET;
            r_lag  <= LAG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_POLY: r_poly <= i_cfg_wdata;
                CFG_LAG:  r_lag  <= i_cfg_wdata[LAG_BITS-1:0];
                default:  ;
            endcase
        end
    end

    // lag stays below the depth, so one compare-subtract wraps the tap
    always_comb begin
        n_idx   = (r_idx == t_idx'(RING_DEPTH - 1)) ? '0 : r_idx + 1'b1;
        tap_sum = {1'b0, r_idx} + (IDX_BITS+1)'(r_lag);
        if (tap_sum >= (IDX_BITS+1)'(RING_DEPTH)) begin
            tap_sum = tap_sum - (IDX_BITS+1)'(RING_DEPTH);
        end
        n_tap = tap_sum[IDX_BITS-1:0];
    end

    assign s1_fire       = r_s1_valid && (r_s1_op == OP_LOAD || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // write-stage datapath: forwarded word beats memory, unwritten entries read zero
    always_comb begin
        if (r_fwd_here) begin
            here_w = r_fwd_word;
        end else begin
            here_w = r_here_vld ? r_rd_here : '0;
        end
        if (r_fwd_tap) begin
            tap_w = r_fwd_word;
        end else begin
            tap_w = r_tap_vld ? r_rd_tap : '0;
        end
        step_w  = times_x(tap_w, r_poly) ^ here_w;
        wr_data = (r_s1_op == OP_STEP) ? step_w : r_s1_seed;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_here <= r_mem[r_idx];
            r_rd_tap  <= r_mem[n_tap];
            r_s1_op   <= t_op'(s_axis_tuser);
            r_s1_seed <= s_axis_tdata;
            r_s1_addr <= r_idx;
        end
        if (s1_fire) begin
            r_mem[r_s1_addr] <= wr_data;
        end
        // the word written this edge also feeds the item read this edge
        if (accept) begin
            r_fwd_word <= wr_data;
        end
        if (s1_fire && r_s1_op == OP_STEP) begin
            r_out_word <= step_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_vld       <= '0;
            r_s1_valid  <= 1'b0;
            r_here_vld  <= 1'b0;
            r_tap_vld   <= 1'b0;
            r_fwd_here  <= 1'b0;
            r_fwd_tap   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_idx      <= n_idx;
                r_here_vld <= r_vld[r_idx];
                r_tap_vld  <= r_vld[n_tap];
                r_fwd_here <= s1_fire && (r_s1_addr == r_idx);
                r_fwd_tap  <= s1_fire && (r_s1_addr == n_tap);
            end
            if (s1_fire) begin
                r_vld[r_s1_addr] <= 1'b1;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && r_s1_op == OP_STEP) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_word;

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_valid && r_s1_op == OP_STEP && r_out_valid && !m_axis_tready)
        else $error("input stalled without a blocked step");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_idx == ($past(r_idx) == t_idx'(RING_DEPTH - 1) ? '0 : $past(r_idx) + 1'b1))
        else $error("ring index did not advance by one");

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_fwd_tap |-> r_lag == t_lag'(RING_DEPTH - 1))
        else $error("tap forwarded from a word that is not one entry behind");

    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_op == OP_STEP))
        else $error("result raised without a step item");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out_word))
        else $error("result changed while waiting for the receiver");
`endif

endmodule

`default_nettype wire
